@@ hw/rtl/limit_order_book_core_assert.svh @@
// Assertion macros for the limit order book core.
// Included by the top level; needs clk and rst in scope where used.
`ifndef LIMIT_ORDER_BOOK_CORE_ASSERT_SVH
`define LIMIT_ORDER_BOOK_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that pre implies post in the same cycle.
`define LOB_ASSERT_SAME(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lob assertion failed");
// Check that pre implies post in the following cycle.
`define LOB_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lob assertion failed");
`else
`define LOB_ASSERT_SAME(name, pre, post)
`define LOB_ASSERT_NEXT(name, pre, post)
`endif
`endif

@@ hw/rtl/lob_pkg.sv @@
// Shared types and codes for the limit order book core.
// No dependencies; used by limit_order_book_core and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package lob_pkg;

  // Operation codes
  localparam logic [2:0] FUNC_INSERT    = 3'd0;
  localparam logic [2:0] FUNC_AMEND     = 3'd1;
  localparam logic [2:0] FUNC_REMOVE    = 3'd2;
  localparam logic [2:0] FUNC_BEST_ID   = 3'd3;
  localparam logic [2:0] FUNC_VOL_QUERY = 3'd4;

  // Status codes
  localparam logic [2:0] STATUS_OK      = 3'd0;
  localparam logic [2:0] STATUS_DUP     = 3'd1;
  localparam logic [2:0] STATUS_UNKNOWN = 3'd2;
  localparam logic [2:0] STATUS_TICK    = 3'd3;
  localparam logic [2:0] STATUS_RANGE   = 3'd4;
  localparam logic [2:0] STATUS_FULL    = 3'd5;

  // Register indexes
  localparam logic REG_TICK_SIZE = 1'b0;

  // Fixed field widths
  localparam int LVL_VOL_W = 42;
  localparam int SUM_W     = 48;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_DECIDE,
    ST_DET_RD,
    ST_DET_UPD,
    ST_PRV_RD,
    ST_PRV_WR,
    ST_NXT_RD,
    ST_NXT_WR,
    ST_BEST_RD,
    ST_BEST_CHK,
    ST_RSC_RD,
    ST_RSC_CHK,
    ST_ATT_RD,
    ST_ATT_UPD,
    ST_TAIL_RD,
    ST_TAIL_WR,
    ST_SLOT_WR,
    ST_SAME_RD,
    ST_SAME_UPD,
    ST_QRY_RD,
    ST_QRY_HEAD,
    ST_QRY_ID,
    ST_VOL_RD,
    ST_VOL_GET,
    ST_PRICE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/lob_div.sv @@
// Radix-2 restoring divider: 32-bit price by 16-bit tick, one bit a cycle.
// Standalone; used by limit_order_book_core for level index and tick check.
`timescale 1ns / 1ps
`default_nettype none
module lob_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [15:0] rem
);

  logic        active;
  logic [4:0]  cnt;
  logic [31:0] acc;
  logic [15:0] part;
  logic [16:0] trial;
  logic        fits;
  logic [15:0] part_next;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial     = {part, acc[31]};
    fits      = trial >= {1'b0, divisor};
    part_next = fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
  end

  // Shift one quotient bit in per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= 5'd0;
        acc    <= dividend;
        part   <= 16'd0;
      end else if (active) begin
        part <= part_next;
        acc  <= {acc[30:0], fits};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quot = acc;
  assign rem  = part;

endmodule
`default_nettype wire

@@ hw/rtl/limit_order_book_core.sv @@
// Limit order book core: price-time priority book over slot and level memories.
// Depends on lob_pkg, lob_div and limit_order_book_core_assert.svh.
//
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+------------------------
//  request   | func order_id side price volume          | start && !busy
//  result    | status result_id result_volume best_*    | done, one cycle
//            | live_orders buy_total sell_total         |
//  config    | psel penable pwrite paddr pwdata prdata  | APB, pready tied high
//
// Every request first runs the divider. Insert, amend and remove then scan the
// whole slot memory through its single read port, then make their link and level
// updates; when a best level empties, a rescan walks away from it level by level.
// After reset a clearing pass over the level and slot memories holds busy high.
// Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "limit_order_book_core_assert.svh"
module limit_order_book_core #(
  parameter int MAX_ORDERS   = 1024,
  parameter int PRICE_LEVELS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [31:0] order_id,
  input  logic        side,
  input  logic [31:0] price,
  input  logic [31:0] volume,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] result_id,
  output logic [47:0] result_volume,
  output logic [31:0] best_bid_price,
  output logic [31:0] best_ask_price,
  output logic [10:0] live_orders,
  output logic [47:0] buy_total,
  output logic [47:0] sell_total
);

  localparam int SW     = (MAX_ORDERS > 2) ? $clog2(MAX_ORDERS) : 1;
  localparam int LW     = (PRICE_LEVELS > 2) ? $clog2(PRICE_LEVELS) : 1;
  localparam int LIW    = LW + 1;
  localparam int LDEPTH = 2 ** LIW;
  localparam int CW     = $clog2(MAX_ORDERS + 1);
  localparam int CLR_N  = (LDEPTH > MAX_ORDERS) ? LDEPTH : MAX_ORDERS;
  localparam int CLRW   = $clog2(CLR_N + 1);
  localparam int VW     = lob_pkg::LVL_VOL_W;
  localparam int TW     = lob_pkg::SUM_W;

  localparam logic [SW:0]     SLOT_END   = (SW + 1)'(MAX_ORDERS);
  localparam logic [SW-1:0]   SLOT_LAST  = SW'(MAX_ORDERS - 1);
  localparam logic [CW-1:0]   CNT_MAX    = CW'(MAX_ORDERS);
  localparam logic [CW-1:0]   CNT_ONE    = CW'(1);
  localparam logic [LW:0]     LVL_END    = (LW + 1)'(PRICE_LEVELS);
  localparam logic [31:0]     LVL_LIMIT  = 32'(PRICE_LEVELS);
  localparam logic [CLRW-1:0] CLR_LAST   = CLRW'(CLR_N - 1);
  localparam logic [CLRW-1:0] CLR_LEVELS = CLRW'(LDEPTH);
  localparam logic [CLRW-1:0] CLR_SLOTS  = CLRW'(MAX_ORDERS);

  typedef struct packed {
    logic          valid;
    logic          side;
    logic [LW-1:0] level;
    logic [31:0]   id;
    logic [31:0]   vol;
    logic [SW-1:0] prev;
    logic [SW-1:0] next;
  } slot_t;

  typedef struct packed {
    logic [SW-1:0] head;
    logic [SW-1:0] tail;
    logic [CW-1:0] count;
    logic [VW-1:0] vol;
  } level_t;

  // Memories
  slot_t  slot_mem  [MAX_ORDERS];
  level_t level_mem [LDEPTH];

  lob_pkg::state_t state, state_next;

  logic [15:0]     tick;
  logic [15:0]     tick_eff;
  logic [2:0]      r_func;
  logic [31:0]     r_id;
  logic            r_side;
  logic [31:0]     r_vol;
  logic [LW-1:0]   q_lvl;
  logic            lvl_ok;
  logic            on_tick;
  logic [SW:0]     si;
  logic            chk_v;
  logic [SW-1:0]   chk_i;
  logic            found;
  logic            free_found;
  logic [SW-1:0]   found_slot;
  logic [SW-1:0]   free_slot;
  slot_t           cur;
  logic            op_side;
  logic [LW-1:0]   op_level;
  logic [SW-1:0]   op_slot;
  logic [SW-1:0]   att_tail;
  logic [LW:0]     rk;
  logic [LW:0]     rk_dn;
  logic [CLRW-1:0] clr;
  logic [LW-1:0]   bid_level;
  logic [LW-1:0]   ask_level;
  logic            bid_present;
  logic            ask_present;
  logic [CW-1:0]   resting;
  logic [TW-1:0]   buy_sum;
  logic [TW-1:0]   sell_sum;
  logic [2:0]      st_r;
  logic [31:0]     rid_r;
  logic [TW-1:0]   rvol_r;
  logic [31:0]     bid_price_r;
  logic [31:0]     ask_price_r;
  logic [LW+15:0]  bid_prod;
  logic [LW+15:0]  ask_prod;

  logic            s_re, s_we;
  logic [SW-1:0]   s_raddr, s_waddr;
  slot_t           s_wdata, s_q;
  logic            l_re, l_we;
  logic [LIW-1:0]  l_raddr, l_waddr;
  level_t          l_wdata, l_q;

  logic            div_start;
  logic            div_done;
  logic [31:0]     div_quot;
  logic [15:0]     div_rem;
  logic            div_in_range;

  logic            scan_hit, scan_free, scan_last;
  logic [2:0]      decide_status;
  logic            det_mid;
  logic [LIW-1:0]  cur_li, op_li, best_li, rsc_li, opp_li;
  logic            opp_present;
  logic            best_present;
  lob_pkg::state_t after_det;
  level_t          det_word, att_word, same_word;
  logic            cfg_write;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == lob_pkg::REG_TICK_SIZE);
  assign prdata    = (paddr[2] == lob_pkg::REG_TICK_SIZE) ? {16'd0, tick} : 32'd0;
  assign tick_eff  = (tick == 16'd0) ? 16'd1 : tick;

  // Level index divider
  assign div_start = (state == lob_pkg::ST_IDLE) && start;

  lob_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (price),
    .divisor  (tick_eff),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign div_in_range = div_quot < LVL_LIMIT;

  // Slot memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (s_we) slot_mem[s_waddr] <= s_wdata;
    if (s_re) s_q <= slot_mem[s_raddr];
  end

  // Level memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (l_we) level_mem[l_waddr] <= l_wdata;
    if (l_re) l_q <= level_mem[l_raddr];
  end

  // Scan compare and decode helpers
  assign scan_hit  = chk_v && s_q.valid && (s_q.id == r_id) && (r_id != 32'd0);
  assign scan_free = chk_v && !s_q.valid;
  assign scan_last = chk_v && (chk_i == SLOT_LAST);
  assign cur_li    = {cur.side, cur.level};
  assign op_li     = {op_side, op_level};
  assign best_li   = op_side ? {1'b1, ask_level} : {1'b0, bid_level};
  assign best_present = op_side ? ask_present : bid_present;
  assign rk_dn     = rk - (LW + 1)'(1);
  assign rsc_li    = op_side ? {1'b1, rk[LW-1:0]} : {1'b0, rk_dn[LW-1:0]};
  assign opp_li    = r_side ? {1'b0, bid_level} : {1'b1, ask_level};
  assign opp_present = r_side ? bid_present : ask_present;
  assign det_mid   = (l_q.count > CNT_ONE) && (l_q.head != op_slot) && (l_q.tail != op_slot);
  assign after_det = (r_func == lob_pkg::FUNC_AMEND) ? lob_pkg::ST_ATT_RD : lob_pkg::ST_PRICE;

  // Check order of the request once the scan is over
  always_comb begin
    decide_status = lob_pkg::STATUS_OK;
    unique case (r_func)
      lob_pkg::FUNC_INSERT: begin
        priority if ((r_id == 32'd0) || found) decide_status = lob_pkg::STATUS_DUP;
        else if (!on_tick) decide_status = lob_pkg::STATUS_TICK;
        else if (!lvl_ok) decide_status = lob_pkg::STATUS_RANGE;
        else if ((resting >= CNT_MAX) || !free_found) decide_status = lob_pkg::STATUS_FULL;
        else decide_status = lob_pkg::STATUS_OK;
      end
      lob_pkg::FUNC_AMEND: begin
        priority if (!found) decide_status = lob_pkg::STATUS_UNKNOWN;
        else if (!on_tick) decide_status = lob_pkg::STATUS_TICK;
        else if (!lvl_ok) decide_status = lob_pkg::STATUS_RANGE;
        else decide_status = lob_pkg::STATUS_OK;
      end
      lob_pkg::FUNC_REMOVE: begin
        if (!found) decide_status = lob_pkg::STATUS_UNKNOWN;
      end
      default: decide_status = lob_pkg::STATUS_OK;
    endcase
  end

  // Build level words for unlink, append and volume change
  always_comb begin
    det_word       = l_q;
    det_word.count = l_q.count - CNT_ONE;
    det_word.vol   = l_q.vol - VW'(cur.vol);
    if (l_q.count > CNT_ONE) begin
      if (l_q.head == op_slot) det_word.head = cur.next;
      else if (l_q.tail == op_slot) det_word.tail = cur.prev;
    end
    att_word       = l_q;
    att_word.head  = (l_q.count == '0) ? op_slot : l_q.head;
    att_word.tail  = op_slot;
    att_word.count = l_q.count + CNT_ONE;
    att_word.vol   = l_q.vol + VW'(r_vol);
    same_word      = l_q;
    same_word.vol  = l_q.vol - VW'(cur.vol) + VW'(r_vol);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= lob_pkg::ST_CLEAR;
    else state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lob_pkg::ST_CLEAR:  if (clr == CLR_LAST) state_next = lob_pkg::ST_IDLE;
      lob_pkg::ST_IDLE:   if (start) state_next = lob_pkg::ST_DIV;
      lob_pkg::ST_DIV: begin
        if (div_done) begin
          unique case (r_func)
            lob_pkg::FUNC_INSERT,
            lob_pkg::FUNC_AMEND,
            lob_pkg::FUNC_REMOVE:    state_next = lob_pkg::ST_SCAN;
            lob_pkg::FUNC_BEST_ID:   state_next = lob_pkg::ST_QRY_RD;
            lob_pkg::FUNC_VOL_QUERY:
              state_next = div_in_range ? lob_pkg::ST_VOL_RD : lob_pkg::ST_PRICE;
            default:                 state_next = lob_pkg::ST_PRICE;
          endcase
        end
      end
      lob_pkg::ST_SCAN:   if (scan_last) state_next = lob_pkg::ST_DECIDE;
      lob_pkg::ST_DECIDE: begin
        if (decide_status != lob_pkg::STATUS_OK) state_next = lob_pkg::ST_PRICE;
        else if (r_func == lob_pkg::FUNC_INSERT) state_next = lob_pkg::ST_ATT_RD;
        else if ((r_func == lob_pkg::FUNC_AMEND) && (q_lvl == cur.level))
          state_next = lob_pkg::ST_SAME_RD;
        else state_next = lob_pkg::ST_DET_RD;
      end
      lob_pkg::ST_DET_RD:  state_next = lob_pkg::ST_DET_UPD;
      lob_pkg::ST_DET_UPD: state_next = det_mid ? lob_pkg::ST_PRV_RD : lob_pkg::ST_BEST_RD;
      lob_pkg::ST_PRV_RD:  state_next = lob_pkg::ST_PRV_WR;
      lob_pkg::ST_PRV_WR:  state_next = lob_pkg::ST_NXT_RD;
      lob_pkg::ST_NXT_RD:  state_next = lob_pkg::ST_NXT_WR;
      lob_pkg::ST_NXT_WR:  state_next = lob_pkg::ST_BEST_RD;
      lob_pkg::ST_BEST_RD: state_next = best_present ? lob_pkg::ST_BEST_CHK : after_det;
      lob_pkg::ST_BEST_CHK: state_next = (l_q.count == '0) ? lob_pkg::ST_RSC_RD : after_det;
      lob_pkg::ST_RSC_RD: begin
        if (op_side) state_next = (rk == LVL_END) ? after_det : lob_pkg::ST_RSC_CHK;
        else state_next = (rk == '0) ? after_det : lob_pkg::ST_RSC_CHK;
      end
      lob_pkg::ST_RSC_CHK: state_next = (l_q.count != '0) ? after_det : lob_pkg::ST_RSC_RD;
      lob_pkg::ST_ATT_RD:  state_next = lob_pkg::ST_ATT_UPD;
      lob_pkg::ST_ATT_UPD:
        state_next = (l_q.count != '0) ? lob_pkg::ST_TAIL_RD : lob_pkg::ST_SLOT_WR;
      lob_pkg::ST_TAIL_RD:  state_next = lob_pkg::ST_TAIL_WR;
      lob_pkg::ST_TAIL_WR:  state_next = lob_pkg::ST_SLOT_WR;
      lob_pkg::ST_SLOT_WR:  state_next = lob_pkg::ST_PRICE;
      lob_pkg::ST_SAME_RD:  state_next = lob_pkg::ST_SAME_UPD;
      lob_pkg::ST_SAME_UPD: state_next = lob_pkg::ST_PRICE;
      lob_pkg::ST_QRY_RD:   state_next = opp_present ? lob_pkg::ST_QRY_HEAD : lob_pkg::ST_PRICE;
      lob_pkg::ST_QRY_HEAD:
        state_next = (l_q.count != '0) ? lob_pkg::ST_QRY_ID : lob_pkg::ST_PRICE;
      lob_pkg::ST_QRY_ID:   state_next = lob_pkg::ST_PRICE;
      lob_pkg::ST_VOL_RD:   state_next = lob_pkg::ST_VOL_GET;
      lob_pkg::ST_VOL_GET:  state_next = lob_pkg::ST_PRICE;
      lob_pkg::ST_PRICE:    state_next = lob_pkg::ST_DONE;
      lob_pkg::ST_DONE:     state_next = lob_pkg::ST_IDLE;
      default:              state_next = lob_pkg::ST_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    s_re    = 1'b0;
    s_raddr = si[SW-1:0];
    s_we    = 1'b0;
    s_waddr = op_slot;
    s_wdata = cur;
    l_re    = 1'b0;
    l_raddr = cur_li;
    l_we    = 1'b0;
    l_waddr = cur_li;
    l_wdata = det_word;
    unique case (state)
      lob_pkg::ST_CLEAR: begin
        l_we    = clr < CLR_LEVELS;
        l_waddr = clr[LIW-1:0];
        l_wdata = '0;
        s_we    = clr < CLR_SLOTS;
        s_waddr = clr[SW-1:0];
        s_wdata = '0;
      end
      lob_pkg::ST_SCAN: s_re = si != SLOT_END;
      lob_pkg::ST_DET_RD: l_re = 1'b1;
      lob_pkg::ST_DET_UPD: begin
        l_we = 1'b1;
        if (r_func == lob_pkg::FUNC_REMOVE) begin
          s_we          = 1'b1;
          s_wdata.valid = 1'b0;
        end
      end
      lob_pkg::ST_PRV_RD: begin
        s_re    = 1'b1;
        s_raddr = cur.prev;
      end
      lob_pkg::ST_PRV_WR: begin
        s_we         = 1'b1;
        s_waddr      = cur.prev;
        s_wdata      = s_q;
        s_wdata.next = cur.next;
      end
      lob_pkg::ST_NXT_RD: begin
        s_re    = 1'b1;
        s_raddr = cur.next;
      end
      lob_pkg::ST_NXT_WR: begin
        s_we         = 1'b1;
        s_waddr      = cur.next;
        s_wdata      = s_q;
        s_wdata.prev = cur.prev;
      end
      lob_pkg::ST_BEST_RD: begin
        l_re    = best_present;
        l_raddr = best_li;
      end
      lob_pkg::ST_RSC_RD: begin
        l_re    = op_side ? (rk != LVL_END) : (rk != '0);
        l_raddr = rsc_li;
      end
      lob_pkg::ST_ATT_RD: begin
        l_re    = 1'b1;
        l_raddr = op_li;
      end
      lob_pkg::ST_ATT_UPD: begin
        l_we    = 1'b1;
        l_waddr = op_li;
        l_wdata = att_word;
      end
      lob_pkg::ST_TAIL_RD: begin
        s_re    = 1'b1;
        s_raddr = att_tail;
      end
      lob_pkg::ST_TAIL_WR: begin
        s_we         = 1'b1;
        s_waddr      = att_tail;
        s_wdata      = s_q;
        s_wdata.next = op_slot;
      end
      lob_pkg::ST_SLOT_WR: begin
        s_we          = 1'b1;
        s_wdata.valid = 1'b1;
        s_wdata.side  = op_side;
        s_wdata.level = op_level;
        s_wdata.id    = r_id;
        s_wdata.vol   = r_vol;
        s_wdata.prev  = att_tail;
      end
      lob_pkg::ST_SAME_RD: l_re = 1'b1;
      lob_pkg::ST_SAME_UPD: begin
        l_we        = 1'b1;
        l_wdata     = same_word;
        s_we        = 1'b1;
        s_wdata.vol = r_vol;
      end
      lob_pkg::ST_QRY_RD: begin
        l_re    = opp_present;
        l_raddr = opp_li;
      end
      lob_pkg::ST_QRY_HEAD: begin
        s_re    = l_q.count != '0;
        s_raddr = l_q.head;
      end
      lob_pkg::ST_VOL_RD: begin
        l_re    = 1'b1;
        l_raddr = {r_side, q_lvl};
      end
      default: ;
    endcase
  end

  // Best prices from level index and tick
  assign bid_prod = bid_level * tick_eff;
  assign ask_prod = ask_level * tick_eff;

  // Book registers and request datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      tick        <= 16'd1;
      clr         <= '0;
      chk_v       <= 1'b0;
      bid_level   <= '0;
      ask_level   <= '0;
      bid_present <= 1'b0;
      ask_present <= 1'b0;
      resting     <= '0;
      buy_sum     <= '0;
      sell_sum    <= '0;
    end else begin
      if (cfg_write) tick <= pwdata[15:0];
      chk_v <= 1'b0;
      unique case (state)
        lob_pkg::ST_CLEAR: clr <= clr + CLRW'(1);
        lob_pkg::ST_IDLE: begin
          if (start) begin
            r_func <= func;
            r_id   <= order_id;
            r_side <= side;
            r_vol  <= volume;
            st_r   <= lob_pkg::STATUS_OK;
            rid_r  <= (func == lob_pkg::FUNC_BEST_ID) ? 32'd0 : order_id;
            rvol_r <= '0;
          end
        end
        lob_pkg::ST_DIV: begin
          if (div_done) begin
            q_lvl      <= div_quot[LW-1:0];
            lvl_ok     <= div_in_range;
            on_tick    <= div_rem == 16'd0;
            si         <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            if ((r_func == lob_pkg::FUNC_VOL_QUERY) && !div_in_range)
              st_r <= lob_pkg::STATUS_RANGE;
          end
        end
        lob_pkg::ST_SCAN: begin
          // Issue the next slot and check the one read last cycle
          if (si != SLOT_END) begin
            si    <= si + (SW + 1)'(1);
            chk_v <= 1'b1;
            chk_i <= si[SW-1:0];
          end
          if (scan_hit && !found) begin
            found      <= 1'b1;
            found_slot <= chk_i;
            cur        <= s_q;
          end
          if (scan_free && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= chk_i;
          end
        end
        lob_pkg::ST_DECIDE: begin
          st_r     <= decide_status;
          op_level <= q_lvl;
          if (r_func == lob_pkg::FUNC_INSERT) begin
            op_slot <= free_slot;
            op_side <= r_side;
          end else begin
            op_slot <= found_slot;
            op_side <= cur.side;
          end
        end
        lob_pkg::ST_DET_UPD: begin
          resting <= resting - CNT_ONE;
          if (op_side) sell_sum <= sell_sum - TW'(cur.vol);
          else buy_sum <= buy_sum - TW'(cur.vol);
        end
        lob_pkg::ST_BEST_CHK: begin
          // Best level emptied: drop it and start the walk away from it
          if (l_q.count == '0) begin
            if (op_side) begin
              ask_present <= 1'b0;
              rk          <= {1'b0, ask_level} + (LW + 1)'(1);
            end else begin
              bid_present <= 1'b0;
              rk          <= {1'b0, bid_level};
            end
          end
        end
        lob_pkg::ST_RSC_RD: begin
          if (op_side && (rk == LVL_END)) ask_level <= '0;
          if (!op_side && (rk == '0)) bid_level <= '0;
        end
        lob_pkg::ST_RSC_CHK: begin
          if (l_q.count != '0) begin
            if (op_side) begin
              ask_level   <= rk[LW-1:0];
              ask_present <= 1'b1;
            end else begin
              bid_level   <= rk_dn[LW-1:0];
              bid_present <= 1'b1;
            end
          end else begin
            rk <= op_side ? rk + (LW + 1)'(1) : rk_dn;
          end
        end
        lob_pkg::ST_ATT_UPD: begin
          att_tail <= l_q.tail;
          resting  <= resting + CNT_ONE;
          if (op_side) begin
            sell_sum <= sell_sum + TW'(r_vol);
            if (!ask_present || (op_level < ask_level)) begin
              ask_level   <= op_level;
              ask_present <= 1'b1;
            end
          end else begin
            buy_sum <= buy_sum + TW'(r_vol);
            if (!bid_present || (op_level > bid_level)) begin
              bid_level   <= op_level;
              bid_present <= 1'b1;
            end
          end
        end
        lob_pkg::ST_SAME_UPD: begin
          if (op_side) sell_sum <= sell_sum - TW'(cur.vol) + TW'(r_vol);
          else buy_sum <= buy_sum - TW'(cur.vol) + TW'(r_vol);
        end
        lob_pkg::ST_QRY_ID:  rid_r  <= s_q.id;
        lob_pkg::ST_VOL_GET: rvol_r <= TW'(l_q.vol);
        lob_pkg::ST_PRICE: begin
          bid_price_r <= bid_present ? 32'(bid_prod) : 32'd0;
          ask_price_r <= ask_present ? 32'(ask_prod) : 32'd0;
        end
        default: ;
      endcase
    end
  end

  // Result ports
  assign busy           = state != lob_pkg::ST_IDLE;
  assign done           = state == lob_pkg::ST_DONE;
  assign status         = st_r;
  assign result_id      = rid_r;
  assign result_volume  = rvol_r;
  assign best_bid_price = bid_price_r;
  assign best_ask_price = ask_price_r;
  assign live_orders    = 11'(resting);
  assign buy_total      = buy_sum;
  assign sell_total     = sell_sum;

  // Checks
  `LOB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `LOB_ASSERT_NEXT(a_done_single, done, !done)
  `LOB_ASSERT_SAME(a_count_cap, 1'b1, resting <= CNT_MAX)
  `LOB_ASSERT_SAME(a_no_bid_price, done && !bid_present, best_bid_price == 32'd0)

endmodule
`default_nettype wire

@@ verif/limit_order_book_core_tb.sv @@
// Self-checking testbench for limit_order_book_core: directed and random requests,
// with tick_size changes over the APB port. Results are checked against a book model.
// Depends on lob_pkg and the limit_order_book_core RTL.
`timescale 1ns / 1ps
module limit_order_book_core_tb;
  import lob_pkg::*;

  localparam int NUM_SLOTS  = 1024;
  localparam int NUM_LEVELS = 1024;
  localparam int STALL_LIMIT = 40000;
  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] order_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] volume;
  } order_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_id;
    logic [47:0] result_volume;
    logic [31:0] best_bid_price;
    logic [31:0] best_ask_price;
    logic [10:0] live_orders;
    logic [47:0] buy_total;
    logic [47:0] sell_total;
  } book_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [2:0] func = '0;
  logic [31:0] order_id = '0;
  logic side = 1'b0;
  logic [31:0] price = '0;
  logic [31:0] volume = '0;
  logic done;
  logic [2:0] status;
  logic [31:0] result_id;
  logic [47:0] result_volume;
  logic [31:0] best_bid_price;
  logic [31:0] best_ask_price;
  logic [10:0] live_orders;
  logic [47:0] buy_total;
  logic [47:0] sell_total;

  limit_order_book_core i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .func(func), .order_id(order_id), .side(side), .price(price), .volume(volume),
    .done(done), .status(status), .result_id(result_id), .result_volume(result_volume),
    .best_bid_price(best_bid_price), .best_ask_price(best_ask_price),
    .live_orders(live_orders), .buy_total(buy_total), .sell_total(sell_total)
  );

  always #5 clk = ~clk;

  // Book model state
  logic [31:0] slot_oid [NUM_SLOTS];
  bit          slot_used [NUM_SLOTS];
  bit          slot_sd [NUM_SLOTS];
  int unsigned slot_lvl [NUM_SLOTS];
  logic [31:0] slot_qty [NUM_SLOTS];
  int unsigned slot_prv [NUM_SLOTS];
  int unsigned slot_nxt [NUM_SLOTS];
  int unsigned lvl_head [2*NUM_LEVELS];
  int unsigned lvl_tail [2*NUM_LEVELS];
  int unsigned lvl_cnt [2*NUM_LEVELS];
  logic [41:0] lvl_qty [2*NUM_LEVELS];
  int unsigned bid_lvl, ask_lvl, resting;
  bit bid_live, ask_live;
  logic [47:0] buy_sum, sell_sum;
  logic [15:0] tick_reg;

  order_req_t   pending_q[$];
  book_report_t report_q[$];
  logic [31:0]  id_pool[$];
  int errors = 0;
  int stall_cycles = 0;
  int cur_tick = 1;

  function automatic int unsigned find_order(logic [31:0] oid);
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_used[i] && slot_oid[i] == oid) return i;
    return NUM_SLOTS;
  endfunction

  function automatic void link_order(int unsigned s, bit sd, int unsigned lvl, logic [31:0] qty);
    int unsigned li;
    li = sd * NUM_LEVELS + lvl;
    slot_sd[s] = sd;
    slot_lvl[s] = lvl;
    slot_qty[s] = qty;
    if (lvl_cnt[li] == 0) begin
      lvl_head[li] = s;
    end else begin
      slot_nxt[lvl_tail[li]] = s;
      slot_prv[s] = lvl_tail[li];
    end
    lvl_tail[li] = s;
    lvl_cnt[li]++;
    lvl_qty[li] = lvl_qty[li] + qty;
    resting++;
    if (sd == SIDE_BUY) begin
      buy_sum = buy_sum + qty;
      if (!bid_live || lvl > bid_lvl) begin
        bid_lvl = lvl;
        bid_live = 1;
      end
    end else begin
      sell_sum = sell_sum + qty;
      if (!ask_live || lvl < ask_lvl) begin
        ask_lvl = lvl;
        ask_live = 1;
      end
    end
  endfunction

  function automatic void unlink_order(int unsigned s);
    bit sd;
    int unsigned lvl, li;
    logic [31:0] qty;
    sd = slot_sd[s];
    lvl = slot_lvl[s];
    li = sd * NUM_LEVELS + lvl;
    qty = slot_qty[s];
    if (lvl_cnt[li] > 1) begin
      if (lvl_head[li] == s) begin
        lvl_head[li] = slot_nxt[s];
      end else if (lvl_tail[li] == s) begin
        lvl_tail[li] = slot_prv[s];
      end else begin
        slot_nxt[slot_prv[s]] = slot_nxt[s];
        slot_prv[slot_nxt[s]] = slot_prv[s];
      end
    end
    lvl_cnt[li]--;
    lvl_qty[li] = lvl_qty[li] - qty;
    resting--;
    // Walk down for the next bid or up for the next ask once the best level empties
    if (sd == SIDE_BUY) begin
      buy_sum = buy_sum - qty;
      if (bid_live && lvl_cnt[bid_lvl] == 0) begin
        bid_live = 0;
        for (int k = bid_lvl; k > 0; k--)
          if (!bid_live && lvl_cnt[k-1] != 0) begin
            bid_lvl = k - 1;
            bid_live = 1;
          end
        if (!bid_live) bid_lvl = 0;
      end
    end else begin
      sell_sum = sell_sum - qty;
      if (ask_live && lvl_cnt[NUM_LEVELS + ask_lvl] == 0) begin
        ask_live = 0;
        for (int k = ask_lvl + 1; k < NUM_LEVELS; k++)
          if (!ask_live && lvl_cnt[NUM_LEVELS + k] != 0) begin
            ask_lvl = k;
            ask_live = 1;
          end
        if (!ask_live) ask_lvl = 0;
      end
    end
  endfunction

  function automatic book_report_t apply_request(order_req_t rq);
    book_report_t r;
    logic [31:0] tk, lvl, s;
    logic [47:0] prod;
    bit on_tick, sd;
    int unsigned li;
    tk = (tick_reg == 0) ? 32'd1 : {16'd0, tick_reg};
    lvl = rq.price / tk;
    on_tick = (rq.price % tk) == 0;
    r = '0;
    r.status = STATUS_OK;
    r.result_id = rq.order_id;
    case (rq.func)
      FUNC_INSERT: begin
        if (rq.order_id == 0 || find_order(rq.order_id) < NUM_SLOTS) r.status = STATUS_DUP;
        else if (!on_tick) r.status = STATUS_TICK;
        else if (lvl >= NUM_LEVELS) r.status = STATUS_RANGE;
        else if (resting >= NUM_SLOTS) r.status = STATUS_FULL;
        else begin
          s = NUM_SLOTS;
          for (int i = NUM_SLOTS - 1; i >= 0; i--)
            if (!slot_used[i]) s = i;
          slot_used[s] = 1;
          slot_oid[s] = rq.order_id;
          link_order(s, rq.side, lvl, rq.volume);
        end
      end
      FUNC_AMEND: begin
        s = (rq.order_id == 0) ? NUM_SLOTS : find_order(rq.order_id);
        if (s >= NUM_SLOTS) r.status = STATUS_UNKNOWN;
        else if (!on_tick) r.status = STATUS_TICK;
        else if (lvl >= NUM_LEVELS) r.status = STATUS_RANGE;
        else if (lvl != slot_lvl[s]) begin
          sd = slot_sd[s];
          unlink_order(s);
          link_order(s, sd, lvl, rq.volume);
        end else begin
          // Same level: swap the volume, keep the queue position
          sd = slot_sd[s];
          li = sd * NUM_LEVELS + lvl;
          lvl_qty[li] = lvl_qty[li] - slot_qty[s] + rq.volume;
          if (sd == SIDE_BUY) buy_sum = buy_sum - slot_qty[s] + rq.volume;
          else sell_sum = sell_sum - slot_qty[s] + rq.volume;
          slot_qty[s] = rq.volume;
        end
      end
      FUNC_REMOVE: begin
        s = (rq.order_id == 0) ? NUM_SLOTS : find_order(rq.order_id);
        if (s >= NUM_SLOTS) r.status = STATUS_UNKNOWN;
        else begin
          unlink_order(s);
          slot_used[s] = 0;
        end
      end
      FUNC_BEST_ID: begin
        r.result_id = '0;
        if (rq.side == SIDE_BUY) begin
          if (ask_live && lvl_cnt[NUM_LEVELS + ask_lvl] != 0)
            r.result_id = slot_oid[lvl_head[NUM_LEVELS + ask_lvl]];
        end else begin
          if (bid_live && lvl_cnt[bid_lvl] != 0) r.result_id = slot_oid[lvl_head[bid_lvl]];
        end
      end
      FUNC_VOL_QUERY: begin
        if (lvl >= NUM_LEVELS) r.status = STATUS_RANGE;
        else r.result_volume = lvl_qty[rq.side * NUM_LEVELS + lvl];
      end
      default: ;
    endcase
    prod = bid_lvl * tk;
    r.best_bid_price = bid_live ? prod[31:0] : '0;
    prod = ask_lvl * tk;
    r.best_ask_price = ask_live ? prod[31:0] : '0;
    r.live_orders = resting;
    r.buy_total = buy_sum;
    r.sell_total = sell_sum;
    return r;
  endfunction

  // Driver: present queued requests with random gaps, predict each on acceptance
  order_req_t cur_req;
  int gap_left = 0;
  bit burst = 0;
  always @(posedge clk) begin
    logic raise;
    raise = 0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && busy) begin
        raise = 1;
      end else if (start) begin
        report_q.push_back(apply_request(cur_req));
      end
      if (!raise) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          cur_req = pending_q.pop_front();
          func <= cur_req.func;
          order_id <= cur_req.order_id;
          side <= cur_req.side;
          price <= cur_req.price;
          volume <= cur_req.volume;
          raise = 1;
          if ($urandom_range(0, 39) == 0) burst = !burst;
          gap_left = burst ? 0 : $urandom_range(0, 10);
        end
      end
      start <= raise;
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    book_report_t want, got;
    if (!rst && done) begin
      got = '{status, result_id, result_volume, best_bid_price, best_ask_price,
              live_orders, buy_total, sell_total};
      if (report_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = report_q.pop_front();
        if (want.status != got.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (want.result_id != got.result_id) begin
          $display("%0t: result_id exp %h got %h", $time, want.result_id, got.result_id);
          errors++;
        end
        if (want.result_volume != got.result_volume) begin
          $display("%0t: result_volume exp %h got %h", $time, want.result_volume,
                   got.result_volume);
          errors++;
        end
        if (want.best_bid_price != got.best_bid_price) begin
          $display("%0t: best_bid_price exp %0d got %0d", $time, want.best_bid_price,
                   got.best_bid_price);
          errors++;
        end
        if (want.best_ask_price != got.best_ask_price) begin
          $display("%0t: best_ask_price exp %0d got %0d", $time, want.best_ask_price,
                   got.best_ask_price);
          errors++;
        end
        if (want.live_orders != got.live_orders) begin
          $display("%0t: live_orders exp %0d got %0d", $time, want.live_orders,
                   got.live_orders);
          errors++;
        end
        if (want.buy_total != got.buy_total) begin
          $display("%0t: buy_total exp %h got %h", $time, want.buy_total, got.buy_total);
          errors++;
        end
        if (want.sell_total != got.sell_total) begin
          $display("%0t: sell_total exp %h got %h", $time, want.sell_total, got.sell_total);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || done || psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_req(logic [2:0] f, logic [31:0] oid, logic sd, logic [31:0] pr,
                           logic [31:0] qty);
    order_req_t rq;
    rq = '{f, oid, sd, pr, qty};
    pending_q.push_back(rq);
  endtask

  function automatic logic [31:0] pick_id(int fresh_pct);
    logic [31:0] oid;
    if (id_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
      oid = $urandom;
      id_pool.push_back(oid);
      return oid;
    end
    return id_pool[$urandom_range(0, id_pool.size() - 1)];
  endfunction

  function automatic logic [31:0] pick_price();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return $urandom;
    if (roll < 10 && cur_tick > 1) return $urandom_range(0, 1023) * cur_tick + 1;
    if (roll < 50) return $urandom_range(500, 520) * cur_tick;
    return $urandom_range(0, NUM_LEVELS - 1) * cur_tick;
  endfunction

  function automatic logic [31:0] pick_volume();
    return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
  endfunction

  task automatic queue_random(int count);
    int unsigned roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) queue_req(FUNC_INSERT, pick_id(60), $urandom, pick_price(), pick_volume());
      else if (roll < 60) queue_req(FUNC_AMEND, pick_id(5), $urandom, pick_price(),
                                    pick_volume());
      else if (roll < 78) queue_req(FUNC_REMOVE, pick_id(5), $urandom, $urandom, $urandom);
      else if (roll < 87) queue_req(FUNC_BEST_ID, pick_id(5), $urandom, $urandom, $urandom);
      else if (roll < 97) queue_req(FUNC_VOL_QUERY, $urandom, $urandom, pick_price(),
                                    $urandom);
      else queue_req(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)), $urandom,
                     $urandom, $urandom, $urandom);
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || start || report_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_tick(logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(REG_TICK_SIZE) * 3'd4;
    pwdata <= {$urandom_range(0, 65535), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    tick_reg = value;
    cur_tick = (value == 0) ? 1 : value;
  endtask

  initial begin
    logic [31:0] oid;
    tick_reg = 16'd1;
    bid_lvl = 0; ask_lvl = 0; bid_live = 0; ask_live = 0; resting = 0;
    buy_sum = '0; sell_sum = '0;
    for (int i = 0; i < NUM_SLOTS; i++) slot_used[i] = 0;
    for (int i = 0; i < 2*NUM_LEVELS; i++) begin
      lvl_cnt[i] = 0;
      lvl_qty[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, each check order, FIFO unlink cases, spare codes
    queue_req(FUNC_INSERT, 32'd0, SIDE_BUY, 32'd5, 32'd10);
    queue_req(FUNC_INSERT, 32'hFFFF_FFFF, SIDE_BUY, 32'd1023, 32'hFFFF_FFFF);
    queue_req(FUNC_INSERT, 32'hFFFF_FFFF, SIDE_SELL, 32'd7, 32'd1);
    queue_req(FUNC_INSERT, 32'd1, SIDE_SELL, 32'd0, 32'd0);
    queue_req(FUNC_INSERT, 32'd2, SIDE_SELL, 32'd1024, 32'd3);
    queue_req(FUNC_INSERT, 32'd3, SIDE_BUY, 32'd1023, 32'd20);
    queue_req(FUNC_INSERT, 32'd4, SIDE_BUY, 32'd1023, 32'd30);
    queue_req(FUNC_BEST_ID, 32'd0, SIDE_BUY, 32'd0, 32'd0);
    queue_req(FUNC_BEST_ID, 32'd0, SIDE_SELL, 32'd0, 32'd0);
    queue_req(FUNC_VOL_QUERY, 32'd0, SIDE_BUY, 32'd1023, 32'd0);
    queue_req(FUNC_VOL_QUERY, 32'd0, SIDE_SELL, 32'hFFFF_FFFF, 32'd0);
    queue_req(FUNC_AMEND, 32'd0, SIDE_BUY, 32'd10, 32'd1);
    queue_req(FUNC_AMEND, 32'd99, SIDE_BUY, 32'd10, 32'd1);
    queue_req(FUNC_AMEND, 32'd3, SIDE_SELL, 32'd1023, 32'd25);
    queue_req(FUNC_AMEND, 32'd3, SIDE_BUY, 32'd1024, 32'd25);
    queue_req(FUNC_REMOVE, 32'd3, SIDE_BUY, 32'd0, 32'd0);
    queue_req(FUNC_AMEND, 32'hFFFF_FFFF, SIDE_BUY, 32'd40, 32'd5);
    queue_req(FUNC_REMOVE, 32'd0, SIDE_BUY, 32'd0, 32'd0);
    queue_req(FUNC_SPARE_FIRST, 32'd1, SIDE_SELL, 32'd1, 32'd1);
    queue_req(FUNC_SPARE_LAST, 32'd1, SIDE_SELL, 32'd1, 32'd1);
    queue_req(FUNC_REMOVE, 32'd4, SIDE_BUY, 32'd0, 32'd0);
    queue_req(FUNC_REMOVE, 32'd1, SIDE_BUY, 32'd0, 32'd0);
    queue_req(FUNC_BEST_ID, 32'd0, SIDE_SELL, 32'd0, 32'd0);
    wait_drained();

    // Zero tick acts as one; then the widest tick with off-tick prices
    write_tick(16'd0);
    queue_req(FUNC_INSERT, 32'd5, SIDE_SELL, 32'd3, 32'd9);
    wait_drained();
    write_tick(16'hFFFF);
    queue_req(FUNC_INSERT, 32'd6, SIDE_SELL, 32'd1, 32'd9);
    queue_req(FUNC_AMEND, 32'd5, SIDE_SELL, 32'd65536, 32'd9);
    queue_req(FUNC_VOL_QUERY, 32'd0, SIDE_SELL, 32'd65536, 32'd0);
    queue_random(100);
    wait_drained();

    // Change tick while orders rest
    write_tick(16'd7);
    queue_random(100);
    wait_drained();

    // Fill the book to capacity and probe the full check, then run random requests
    write_tick(16'd1);
    for (int n = 0; n < 1040; n++) begin
      oid = $urandom | 32'h1;
      id_pool.push_back(oid);
      queue_req(FUNC_INSERT, oid, $urandom, $urandom_range(0, NUM_LEVELS - 1), pick_volume());
    end
    queue_random(60);
    wait_drained();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lob_pkg.sv
hw/rtl/lob_div.sv
hw/rtl/limit_order_book_core.sv
verif/limit_order_book_core_tb.sv
